[src/bb3_pkg.sv]
`default_nettype none

package bb3_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CHAN_W    = 8;
    localparam int PIX_W     = 3 * CHAN_W;

    localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    // The input row runs up to two past the last row while the pipeline drains.
    localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int OROW_W = $clog2(MAX_HEIGHT);

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Sum of up to nine channel values, and the pixel count of a window.
    localparam int SUM_W  = $clog2(9 * 255 + 1);
    localparam int CNT_W  = 4;
    localparam int NUM_W  = SUM_W + 1;
    localparam int RCP_SH = 18;
    localparam int RCP_W  = 18;

    localparam int OUT_DEPTH = 4;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic              op;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              frame_last;
    } pix_out_t;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] col;
        pix_t             px;
    } ls_wr_t;

    // Pixel count of the window from the number of rows and columns in bounds.
    function automatic logic [CNT_W-1:0] window_count(input logic [1:0] rows,
                                                      input logic [1:0] cols);
        logic [CNT_W-1:0] n;
        n = CNT_W'(rows) * CNT_W'(cols);
        return n;
    endfunction

    // ceil(2^RCP_SH / (2n)): exact quotient of (2*sum + n) / (2n) for all
    // sums that nine 8-bit values can reach.
    function automatic logic [RCP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
        logic [RCP_W-1:0] m;
        case (n)
            4'd1:    m = RCP_W'(131072);
            4'd2:    m = RCP_W'(65536);
            4'd3:    m = RCP_W'(43691);
            4'd4:    m = RCP_W'(32768);
            4'd6:    m = RCP_W'(21846);
            4'd9:    m = RCP_W'(14564);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[src/bb3_line_store.sv]
`default_nettype none

module bb3_line_store (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire [bb3_pkg::COL_W-1:0] rd_col,
    input  bb3_pkg::ls_wr_t        wr,
    output bb3_pkg::pix_t          up,
    output bb3_pkg::pix_t          mid
);
    import bb3_pkg::*;

    pix_t upper_mem  [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];

    pix_t upper_rd_reg;
    pix_t middle_rd_reg;
    pix_t fwd_up_reg;
    pix_t fwd_mid_reg;
    logic fwd_reg;

    // A read at the column being written in the same cycle (one pixel wide
    // images) takes the values being written instead of the stale entry.
    assign up  = fwd_reg ? fwd_up_reg  : upper_rd_reg;
    assign mid = fwd_reg ? fwd_mid_reg : middle_rd_reg;

    always_ff @(posedge clk)
    begin
        upper_rd_reg  <= upper_mem[rd_col];
        middle_rd_reg <= middle_mem[rd_col];
        fwd_up_reg    <= mid;
        fwd_mid_reg   <= wr.px;
        if (wr.en)
        begin
            upper_mem[wr.col]  <= mid;
            middle_mem[wr.col] <= wr.px;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= wr.en && (wr.col == rd_col);
        end
    end

endmodule

`default_nettype wire

[src/bb3_chan_div.sv]
`default_nettype none

module bb3_chan_div (
    input  wire [bb3_pkg::SUM_W-1:0]  sum,
    input  wire [bb3_pkg::CNT_W-1:0]  n,
    input  wire [bb3_pkg::RCP_W-1:0]  recip,
    output logic [bb3_pkg::CHAN_W-1:0] avg
);
    import bb3_pkg::*;

    logic [NUM_W-1:0]       num;
    logic [NUM_W+RCP_W-1:0] prod;

    // Round half up: (2*sum + n) / (2n), by multiplying with the reciprocal.
    always_comb
    begin
        num  = {sum, 1'b0} + NUM_W'(n);
        prod = (NUM_W+RCP_W)'(num) * (NUM_W+RCP_W)'(recip);
        avg  = prod[RCP_SH +: CHAN_W];
    end

endmodule

`default_nettype wire

[src/box_blur_3x3_rgb.sv]
`default_nettype none

// 3x3 box blur of an RGB raster stream. Send image_width*image_height pixel
// beats, then image_width+1 further beats (flush beats, or pixels whose data
// is dropped) to drain the last row. The blurred pixel for input position p
// is produced by the beat with index p+image_width+1 and is offered on the
// result port after stage 1, stage 2 and the output buffer. The last one of
// the frame has frame_last set. Each output averages only the neighbors
// inside the image (9, 6 or 4, fewer for one pixel wide or high images),
// rounded half up. While pix_stall is low, one beat is accepted every clock
// cycle. The line stores are simple dual-port memories with a registered
// read. The window update and the sums share one pipeline stage, and the
// reciprocal multiply takes a second. A four-beat output buffer keeps input
// flowing while results wait; pix_stall rises only when that buffer and the
// beats in flight would fill it. A flush beat during a frame is ignored.
// Writing either dimension register restarts the frame; values of zero read
// as one and values above 2048 as 2048. The line stores are not cleared
// after reset; no output depends on an entry the frame has not written.
module box_blur_3x3_rgb (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        pix_valid,
    output logic                       pix_stall,
    input  bb3_pkg::pix_in_t           pix_data,
    output logic                       res_valid,
    input  wire                        res_stall,
    output bb3_pkg::pix_out_t          res_data,
    input  wire                        cfg_we,
    input  wire [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [bb3_pkg::CFG_W-1:0]   cfg_data
);
    import bb3_pkg::*;

    logic [WDIM_W-1:0] width_reg;
    logic [HDIM_W-1:0] height_reg;

    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [IROW_W-1:0] in_row_reg,  in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;

    logic       in_acc;
    logic       draining;
    logic       advance;
    logic       emit;
    logic       in_wrap;
    logic       out_wrap;
    logic       is_last;
    logic [3:0] mask;
    pix_t       px;
    logic [WDIM_W-1:0] width_fit;
    logic [HDIM_W-1:0] height_fit;

    // Stage 1: beat accepted, line store read in flight.
    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic [COL_W-1:0] s1_col_reg;
    pix_t             s1_px_reg;
    logic [3:0]       s1_mask_reg;
    logic             s1_last_reg;

    pix_t   ls_up;
    pix_t   ls_mid;
    ls_wr_t ls_wr;

    pix_t win_reg  [9];
    pix_t win_next [9];

    logic [SUM_W-1:0] sum_r, sum_g, sum_b;
    logic [1:0]       rows, cols;
    logic [CNT_W-1:0] cnt;

    // Stage 2: sums and divisor.
    logic             s2_valid_reg;
    logic [SUM_W-1:0] s2_sum_r_reg, s2_sum_g_reg, s2_sum_b_reg;
    logic [CNT_W-1:0] s2_n_reg;
    logic [RCP_W-1:0] s2_rcp_reg;
    logic             s2_last_reg;

    pix_out_t res_new;

    pix_out_t          obuf_reg [OUT_DEPTH];
    logic [OPTR_W-1:0] wr_ptr_reg;
    logic [OPTR_W-1:0] rd_ptr_reg;
    logic [OCNT_W-1:0] ocnt_reg, ocnt_next;
    logic              pop;

    // Room check uses registered state only, counting beats still in flight.
    assign pix_stall = (ocnt_reg + OCNT_W'(s1_emit_reg) + OCNT_W'(s2_valid_reg))
                       >= OCNT_W'(OUT_DEPTH);
    assign in_acc    = pix_valid && !pix_stall;
    assign res_valid = (ocnt_reg != '0);
    assign res_data  = obuf_reg[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;

    always_comb
    begin
        if (cfg_data == '0)
            width_fit = WDIM_W'(1);
        else if (32'(cfg_data) > MAX_WIDTH)
            width_fit = WDIM_W'(MAX_WIDTH);
        else
            width_fit = WDIM_W'(cfg_data);

        if (cfg_data == '0)
            height_fit = HDIM_W'(1);
        else if (32'(cfg_data) > MAX_HEIGHT)
            height_fit = HDIM_W'(MAX_HEIGHT);
        else
            height_fit = HDIM_W'(cfg_data);
    end

    always_comb
    begin
        draining = (32'(in_row_reg) >= 32'(height_reg));
        advance  = in_acc && (draining || (pix_data.op == OP_PIXEL));
        px       = draining ? '0 : {pix_data.red_in, pix_data.green_in, pix_data.blue_in};
        // Nothing comes out until the window has reached one row and one pixel.
        emit     = advance && !((in_row_reg == '0) ||
                                ((in_row_reg == IROW_W'(1)) && (in_col_reg == '0)));
        in_wrap  = (32'(in_col_reg) + 1) >= 32'(width_reg);
        out_wrap = (32'(out_col_reg) + 1) >= 32'(width_reg);
        is_last  = ((32'(out_row_reg) + 1) == 32'(height_reg)) && out_wrap;
        // mask: top row, bottom row, left column, right column in bounds.
        mask[3]  = (out_row_reg != '0);
        mask[2]  = (32'(out_row_reg) + 1) < 32'(height_reg);
        mask[1]  = (out_col_reg != '0);
        mask[0]  = !out_wrap;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (advance)
        begin
            if (in_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end
        if (emit)
        begin
            if (out_wrap)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + OROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
            if (is_last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
        if (cfg_we)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WDIM_W'(RESET_WIDTH);
            height_reg  <= HDIM_W'(RESET_HEIGHT);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_IMAGE_WIDTH))
                width_reg <= width_fit;
            if (cfg_we && (cfg_index == REG_IMAGE_HEIGHT))
                height_reg <= height_fit;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= advance;
            s1_emit_reg  <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_col_reg  <= in_col_reg;
        s1_px_reg   <= px;
        s1_mask_reg <= mask;
        s1_last_reg <= is_last;
    end

    assign ls_wr.en  = s1_valid_reg;
    assign ls_wr.col = s1_col_reg;
    assign ls_wr.px  = s1_px_reg;

    bb3_line_store u_line_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_col (in_col_reg),
        .wr     (ls_wr),
        .up     (ls_up),
        .mid    (ls_mid)
    );

    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = ls_up;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = ls_mid;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_px_reg;

        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (((i / 3 != 0) || s1_mask_reg[3]) && ((i / 3 != 2) || s1_mask_reg[2]) &&
                ((i % 3 != 0) || s1_mask_reg[1]) && ((i % 3 != 2) || s1_mask_reg[0]))
            begin
                sum_r = sum_r + SUM_W'(win_next[i][2*CHAN_W +: CHAN_W]);
                sum_g = sum_g + SUM_W'(win_next[i][CHAN_W +: CHAN_W]);
                sum_b = sum_b + SUM_W'(win_next[i][0 +: CHAN_W]);
            end
        end
        rows = 2'd1 + 2'(s1_mask_reg[3]) + 2'(s1_mask_reg[2]);
        cols = 2'd1 + 2'(s1_mask_reg[1]) + 2'(s1_mask_reg[0]);
        cnt  = window_count(rows, cols);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                for (int i = 0; i < 9; i++)
                    win_reg[i] <= win_next[i];
            end
            s2_valid_reg <= s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_sum_r_reg <= sum_r;
        s2_sum_g_reg <= sum_g;
        s2_sum_b_reg <= sum_b;
        s2_n_reg     <= cnt;
        s2_rcp_reg   <= recip_of(cnt);
        s2_last_reg  <= s1_last_reg;
    end

    bb3_chan_div u_div_r (
        .sum   (s2_sum_r_reg),
        .n     (s2_n_reg),
        .recip (s2_rcp_reg),
        .avg   (res_new.red_out)
    );

    bb3_chan_div u_div_g (
        .sum   (s2_sum_g_reg),
        .n     (s2_n_reg),
        .recip (s2_rcp_reg),
        .avg   (res_new.green_out)
    );

    bb3_chan_div u_div_b (
        .sum   (s2_sum_b_reg),
        .n     (s2_n_reg),
        .recip (s2_rcp_reg),
        .avg   (res_new.blue_out)
    );

    assign res_new.frame_last = s2_last_reg;

    always_comb
    begin
        ocnt_next = ocnt_reg;
        if (s2_valid_reg && !pop)
            ocnt_next = ocnt_reg + OCNT_W'(1);
        else if (!s2_valid_reg && pop)
            ocnt_next = ocnt_reg - OCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            ocnt_reg   <= '0;
        end
        else
        begin
            if (s2_valid_reg)
                wr_ptr_reg <= wr_ptr_reg + OPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OPTR_W'(1);
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
            obuf_reg[wr_ptr_reg] <= res_new;
    end

endmodule

`default_nettype wire
